FILE: src/bzc_pkg.sv
// Package for the reaction automaton cell engine: grid sizes, field widths,
// command codes and the request type of the shared arithmetic unit.
// No dependencies.
`default_nettype none

package bzc_pkg;

    localparam int GRID_WIDTH     = 16;
    localparam int GRID_HEIGHT    = 16;
    localparam int CELLS_PER_BANK = GRID_WIDTH * GRID_HEIGHT;
    localparam int MEM_DEPTH      = 2 * CELLS_PER_BANK;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);

    localparam int CMD_W   = 2;
    localparam int COORD_W = 4;
    localparam int CONC_W  = 8;
    localparam int CELL_W  = 3 * CONC_W;

    // Sum of nine 8-bit values.
    localparam int SUM_W = 12;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd2;

    // Division by 9 as multiplication by ceil(2^16 / 9) and a shift; exact
    // for every sum below 2^15.
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = 13;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

    localparam int REACT_BIAS = 259;
    localparam int REACT_W    = 10;
    localparam int REACT_SHIFT = 8;

    typedef struct packed {
        logic              is_div;
        logic [SUM_W-1:0]  sum;
        logic [CONC_W-1:0] p;
        logic [CONC_W-1:0] q;
        logic [CONC_W-1:0] r;
    } alu_req_t;

endpackage

`default_nettype wire

FILE: src/bz_reaction_automaton_cell_top.sv
// Top level of the reaction automaton cell engine: command sequencer, the
// two-bank cell memory and the result register. Depends on bzc_pkg, bzc_alu.
`default_nettype none

// The block holds three 8-bit concentration planes per cell of a toroidal
// grid in one memory of two banks, each entry packing a, b and c. A load item
// writes one cell of the current bank and a commit item swaps the banks; each
// is done on acceptance and the block is ready again at once. A compute item reads
// the nine cells of the wrapped 3x3 neighborhood one per cycle through the
// single memory port, then makes six passes through one shared multiplier
// (three divisions by nine, three reaction terms), then writes the new cell
// into the other bank and places the result in the output register. From
// acceptance until it is through the block takes no new item, so compute items
// cannot overlap; the nine memory reads and the six multiplier passes set how
// long it is busy. The write and the hand-off wait while an earlier result has
// not been taken. Load and compute items whose col or row lies off the grid,
// and the unused command code, are accepted and dropped without a result.
// Reading a cell that was never written returns whatever the memory holds.
module bz_reaction_automaton_cell_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bzc_pkg::CMD_W-1:0]     cmd,
    input  wire logic [bzc_pkg::COORD_W-1:0]   col,
    input  wire logic [bzc_pkg::COORD_W-1:0]   row,
    input  wire logic [bzc_pkg::CONC_W-1:0]    load_a,
    input  wire logic [bzc_pkg::CONC_W-1:0]    load_b,
    input  wire logic [bzc_pkg::CONC_W-1:0]    load_c,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bzc_pkg::CONC_W-1:0]         new_a,
    output logic [bzc_pkg::CONC_W-1:0]         new_b,
    output logic [bzc_pkg::CONC_W-1:0]         new_c
);
    import bzc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    localparam logic [1:0] NB_LAST  = 2'd2;
    localparam logic [2:0] STEP_LAST = 3'd5;

    logic [2:0] state_reg, state_next;

    logic bank_select_reg;
    logic [1:0] dx_reg, dy_reg;
    logic [2:0] step_reg;
    logic rd_valid_reg;

    logic [COORD_W-1:0] col_reg, row_reg;
    logic [COORD_W-1:0] col_m_reg, col_p_reg, row_m_reg, row_p_reg;
    logic [SUM_W-1:0]   sum_a_reg, sum_b_reg, sum_c_reg;
    logic [CONC_W-1:0]  avg_a_reg, avg_b_reg, avg_c_reg;
    logic [CONC_W-1:0]  na_reg, nb_reg, nc_reg;

    logic [CELL_W-1:0]  mem [0:MEM_DEPTH-1];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_wdata;

    logic               out_valid_reg;
    logic [CONC_W-1:0]  out_a_reg, out_b_reg, out_c_reg;

    logic accept;
    logic on_grid;
    logic finish;
    logic [COORD_W-1:0] nb_x, nb_y;
    logic [CONC_W-1:0]  mix;

    alu_req_t          alu_req;
    logic [CONC_W-1:0] alu_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic bank,
                                                    input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(CELLS_PER_BANK) : '0;
        return base + ADDR_W'(y) * ADDR_W'(GRID_WIDTH) + ADDR_W'(x);
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign on_grid   = (32'(col) < 32'(GRID_WIDTH)) && (32'(row) < 32'(GRID_HEIGHT));
    assign finish    = (state_reg == ST_WRITE) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign new_a     = out_a_reg;
    assign new_b     = out_b_reg;
    assign new_c     = out_c_reg;

    // Neighbor selection: index 0 is the lower neighbor, 1 the cell, 2 the upper.
    always_comb
    begin
        case (dx_reg)
            2'd0:    nb_x = col_m_reg;
            2'd1:    nb_x = col_reg;
            default: nb_x = col_p_reg;
        endcase
        case (dy_reg)
            2'd0:    nb_y = row_m_reg;
            2'd1:    nb_y = row_reg;
            default: nb_y = row_p_reg;
        endcase
    end

    assign mix = (na_reg >> 4) + nc_reg;

    // The memory has a single port: loads write in idle, a compute writes
    // its new cell at the end, and all other cycles read.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = {load_a, load_b, load_c};
        mem_addr  = cell_addr(bank_select_reg, nb_x, nb_y);
        if (accept && cmd == CMD_LOAD && on_grid)
        begin
            mem_we   = 1'b1;
            mem_addr = cell_addr(bank_select_reg, col, row);
        end
        else if (finish)
        begin
            mem_we    = 1'b1;
            mem_wdata = {na_reg, nb_reg, mix};
            mem_addr  = cell_addr(~bank_select_reg, col_reg, row_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    // Operands for the shared unit: three divisions, then the three
    // rotations of the reaction term.
    always_comb
    begin
        alu_req.is_div = 1'b1;
        alu_req.sum    = sum_a_reg;
        alu_req.p      = avg_a_reg;
        alu_req.q      = avg_b_reg;
        alu_req.r      = avg_c_reg;
        case (step_reg)
            3'd0: alu_req.sum = sum_a_reg;
            3'd1: alu_req.sum = sum_b_reg;
            3'd2: alu_req.sum = sum_c_reg;
            3'd3:
            begin
                alu_req.is_div = 1'b0;
            end
            3'd4:
            begin
                alu_req.is_div = 1'b0;
                alu_req.p      = avg_b_reg;
                alu_req.q      = avg_c_reg;
                alu_req.r      = avg_a_reg;
            end
            default:
            begin
                alu_req.is_div = 1'b0;
                alu_req.p      = avg_c_reg;
                alu_req.q      = avg_a_reg;
                alu_req.r      = avg_b_reg;
            end
        endcase
    end

    bzc_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && cmd == CMD_COMPUTE && on_grid)
                    state_next = ST_READ;
            ST_READ:
                if (dx_reg == NB_LAST && dy_reg == NB_LAST)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_CALC;
            ST_CALC:
                if (step_reg == STEP_LAST)
                    state_next = ST_WRITE;
            ST_WRITE:
                if (finish)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bank_select_reg <= 1'b0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            step_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_READ);

            if (accept && cmd == CMD_COMMIT)
                bank_select_reg <= ~bank_select_reg;

            if (state_reg == ST_READ)
            begin
                if (dx_reg == NB_LAST)
                begin
                    dx_reg <= '0;
                    dy_reg <= dy_reg + 2'd1;
                end
                else
                begin
                    dx_reg <= dx_reg + 2'd1;
                end
            end
            else
            begin
                dx_reg <= '0;
                dy_reg <= '0;
            end

            if (state_reg == ST_CALC)
                step_reg <= step_reg + 3'd1;
            else
                step_reg <= '0;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg   <= col;
            row_reg   <= row;
            col_m_reg <= (col == '0) ? COORD_W'(GRID_WIDTH - 1) : col - 1'b1;
            col_p_reg <= (32'(col) + 1 >= GRID_WIDTH) ? '0 : col + 1'b1;
            row_m_reg <= (row == '0) ? COORD_W'(GRID_HEIGHT - 1) : row - 1'b1;
            row_p_reg <= (32'(row) + 1 >= GRID_HEIGHT) ? '0 : row + 1'b1;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_c_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_a_reg <= sum_a_reg + SUM_W'(rd_data_reg[2*CONC_W +: CONC_W]);
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data_reg[CONC_W +: CONC_W]);
            sum_c_reg <= sum_c_reg + SUM_W'(rd_data_reg[0 +: CONC_W]);
        end

        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                3'd0:    avg_a_reg <= alu_result;
                3'd1:    avg_b_reg <= alu_result;
                3'd2:    avg_c_reg <= alu_result;
                3'd3:    na_reg    <= alu_result;
                3'd4:    nb_reg    <= alu_result;
                default: nc_reg    <= alu_result;
            endcase
        end

        if (finish)
        begin
            out_a_reg <= na_reg;
            out_b_reg <= nb_reg;
            out_c_reg <= nc_reg;
        end
    end

    // The memory port is written only by a load in idle or by the final
    // write of a compute, never while neighbors are being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_WRITE))
        else $error("cell memory written during a neighborhood read");

    // Read data is accumulated only in the cycle after a read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg) == ST_READ)
        else $error("read data flagged valid without a preceding read");

    // Completing a compute always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("finished compute did not present a result");

    // The bank changes only on an accepted commit item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && cmd == CMD_COMMIT) |=> $stable(bank_select_reg))
        else $error("bank select changed without a commit");

endmodule

`default_nettype wire

FILE: src/bzc_alu.sv
// Shared arithmetic unit: one multiplier that either divides a neighborhood
// sum by nine or forms one clamped reaction term. Depends on bzc_pkg.
`default_nettype none

module bzc_alu (
    input  var bzc_pkg::alu_req_t             req,
    output logic [bzc_pkg::CONC_W-1:0]        result
);
    import bzc_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [SUM_W-1:0]   mul_a;
    logic [RECIP_W-1:0] mul_b;
    logic [PROD_W-1:0]  product;
    logic [REACT_W-1:0] factor;
    logic [CONC_W:0]    react_val;

    // 259 + q - r stays within 4 to 514.
    assign factor = REACT_W'(REACT_BIAS) + REACT_W'(req.q) - REACT_W'(req.r);

    always_comb
    begin
        if (req.is_div)
        begin
            mul_a = req.sum;
            mul_b = RECIP_NINE;
        end
        else
        begin
            mul_a = SUM_W'(req.p);
            mul_b = RECIP_W'(factor);
        end
    end

    assign product   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign react_val = product[REACT_SHIFT +: CONC_W + 1];

    always_comb
    begin
        if (req.is_div)
            result = product[DIV_SHIFT +: CONC_W];
        else if (react_val[CONC_W])
            result = {CONC_W{1'b1}};
        else
            result = react_val[CONC_W-1:0];
    end

endmodule

`default_nettype wire
